// ===== hw/rtl/bsc_pkg.sv =====
// shared types and constants for the barometric compensation pipeline
package bsc_pkg;

  localparam int unsigned CoefWidth  = 16;
  localparam int unsigned RawWidth   = 24;
  localparam int unsigned TempWidth  = 19;
  localparam int unsigned PresWidth  = 24;
  localparam int unsigned CfgIdxWidth = 3;

  // first-order formula scaling, as shift counts
  localparam int unsigned DtShift     = 8;
  localparam int unsigned TempShift   = 23;
  localparam int unsigned OffShift    = 17;
  localparam int unsigned OffDtShift  = 6;
  localparam int unsigned SensShift   = 16;
  localparam int unsigned SensDtShift = 7;
  localparam int unsigned PSensShift  = 21;
  localparam int unsigned PFinalShift = 15;
  localparam int          TempBase    = 2000;

  // internal widths
  localparam int unsigned DtWidth   = RawWidth + 1;   // signed delta temperature
  localparam int unsigned ProdWidth = 42;             // dT times one coefficient
  localparam int unsigned OffWidth  = 37;
  localparam int unsigned SensWidth = 36;
  localparam int unsigned SensLoWidth = 18;
  localparam int unsigned SensHiWidth = SensWidth - SensLoWidth;
  localparam int unsigned PLoWidth  = 42;
  localparam int unsigned PHiWidth  = 43;
  localparam int unsigned PFullWidth = 61;
  localparam int unsigned DiffWidth = 41;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_PRESSURE_SENSITIVITY   = 3'd0,
    CFG_PRESSURE_OFFSET        = 3'd1,
    CFG_SENSITIVITY_TEMP_COEFF = 3'd2,
    CFG_OFFSET_TEMP_COEFF      = 3'd3,
    CFG_REFERENCE_TEMPERATURE  = 3'd4,
    CFG_TEMPERATURE_SLOPE      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CoefWidth-1:0] pressure_sensitivity;
    logic [CoefWidth-1:0] pressure_offset;
    logic [CoefWidth-1:0] sensitivity_temp_coeff;
    logic [CoefWidth-1:0] offset_temp_coeff;
    logic [CoefWidth-1:0] reference_temperature;
    logic [CoefWidth-1:0] temperature_slope;
  } cal_t;

  // hand-off from the coefficient stages to the pressure stages
  typedef struct packed {
    logic                        valid;
    logic [RawWidth-1:0]         raw_pressure;
    logic signed [TempWidth-1:0] temperature;
    logic signed [OffWidth-1:0]  off;
    logic signed [SensWidth-1:0] sens;
  } comp_t;

endpackage

// ===== hw/rtl/bsc_cfg_regs.sv =====
// calibration coefficient registers with a valid/ready write channel
module bsc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bsc_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [bsc_pkg::CoefWidth-1:0]    cfg_data_i,
  output bsc_pkg::cal_t                    cal_o
);
  import bsc_pkg::*;

  cal_t cal_q, cal_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cal_d = cal_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PRESSURE_SENSITIVITY:   cal_d.pressure_sensitivity   = cfg_data_i;
        CFG_PRESSURE_OFFSET:        cal_d.pressure_offset        = cfg_data_i;
        CFG_SENSITIVITY_TEMP_COEFF: cal_d.sensitivity_temp_coeff = cfg_data_i;
        CFG_OFFSET_TEMP_COEFF:      cal_d.offset_temp_coeff      = cfg_data_i;
        CFG_REFERENCE_TEMPERATURE:  cal_d.reference_temperature  = cfg_data_i;
        CFG_TEMPERATURE_SLOPE:      cal_d.temperature_slope      = cfg_data_i;
        default:                    cal_d = cal_q;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

// ===== hw/rtl/bsc_coef_pipe.sv =====
// stages 1-3: delta temperature, coefficient products, temperature/off/sens
module bsc_coef_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [bsc_pkg::RawWidth-1:0]  raw_pressure_i,
  input  logic [bsc_pkg::RawWidth-1:0]  raw_temperature_i,
  input  bsc_pkg::cal_t                 cal_i,
  output bsc_pkg::comp_t                comp_o
);
  import bsc_pkg::*;

  logic                        v1_q, v2_q, v3_q;
  logic [RawWidth-1:0]         d1_s1_q, d1_s2_q, d1_s3_q;

  // stage 1
  logic signed [DtWidth-1:0]   dt_d, dt_q;
  // stage 2
  logic signed [ProdWidth-1:0] tprod_d, oprod_d, sprod_d;
  logic signed [ProdWidth-1:0] tprod_q, oprod_q, sprod_q;
  // stage 3
  logic signed [ProdWidth-1:0] tsum, osum, ssum, tq, oq, sq;
  logic signed [TempWidth-1:0] temp_d, temp_q;
  logic signed [OffWidth-1:0]  off_d, off_q;
  logic signed [SensWidth-1:0] sens_d, sens_q;

  assign dt_d = $signed({1'b0, raw_temperature_i})
              - $signed({1'b0, cal_i.reference_temperature, {DtShift{1'b0}}});

  assign tprod_d = dt_q * $signed({1'b0, cal_i.temperature_slope});
  assign oprod_d = dt_q * $signed({1'b0, cal_i.offset_temp_coeff});
  assign sprod_d = dt_q * $signed({1'b0, cal_i.sensitivity_temp_coeff});

  // truncate toward zero: bias negative values by divisor minus one
  assign tsum = tprod_q + $signed({{(ProdWidth-TempShift){1'b0}},
                                   {TempShift{tprod_q[ProdWidth-1]}}});
  assign osum = oprod_q + $signed({{(ProdWidth-OffDtShift){1'b0}},
                                   {OffDtShift{oprod_q[ProdWidth-1]}}});
  assign ssum = sprod_q + $signed({{(ProdWidth-SensDtShift){1'b0}},
                                   {SensDtShift{sprod_q[ProdWidth-1]}}});
  assign tq = tsum >>> TempShift;
  assign oq = osum >>> OffDtShift;
  assign sq = ssum >>> SensDtShift;

  assign temp_d = $signed(tq[TempWidth-1:0]) + TempWidth'(TempBase);
  assign off_d  = $signed({{(OffWidth-CoefWidth-OffShift){1'b0}},
                           cal_i.pressure_offset, {OffShift{1'b0}}})
                + OffWidth'(oq);
  assign sens_d = $signed({{(SensWidth-CoefWidth-SensShift){1'b0}},
                           cal_i.pressure_sensitivity, {SensShift{1'b0}}})
                + SensWidth'(sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    d1_s1_q <= raw_pressure_i;
    tprod_q <= tprod_d;
    oprod_q <= oprod_d;
    sprod_q <= sprod_d;
    d1_s2_q <= d1_s1_q;
    temp_q  <= temp_d;
    off_q   <= off_d;
    sens_q  <= sens_d;
    d1_s3_q <= d1_s2_q;
  end

  assign comp_o.valid        = v3_q;
  assign comp_o.raw_pressure = d1_s3_q;
  assign comp_o.temperature  = temp_q;
  assign comp_o.off          = off_q;
  assign comp_o.sens         = sens_q;

endmodule

// ===== hw/rtl/bsc_pres_pipe.sv =====
// stages 4-7: split d1*sens product, recombine, scale and subtract offset, final scale
module bsc_pres_pipe (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bsc_pkg::comp_t                        comp_i,
  output logic                                  valid_o,
  output logic signed [bsc_pkg::TempWidth-1:0]  temperature_o,
  output logic signed [bsc_pkg::PresWidth-1:0]  pressure_o
);
  import bsc_pkg::*;

  logic                        v4_q, v5_q, v6_q, v7_q;
  logic signed [TempWidth-1:0] t4_q, t5_q, t6_q, t7_q;
  logic signed [OffWidth-1:0]  off4_q, off5_q;

  // stage 4: two partial products of d1 against sens halves
  logic [SensLoWidth-1:0]         sens_lo;
  logic signed [SensHiWidth-1:0]  sens_hi;
  logic [PLoWidth-1:0]            plo_d, plo_q;
  logic signed [PHiWidth-1:0]     phi_d, phi_q;
  // stage 5
  logic signed [PFullWidth-1:0]   prod_d, prod_q;
  // stage 6
  logic signed [PFullWidth-1:0]   psum, pq;
  logic signed [DiffWidth-1:0]    diff_d, diff_q;
  // stage 7
  logic signed [DiffWidth-1:0]    dsum, dq;
  logic signed [PresWidth-1:0]    pres_d, pres_q;

  assign sens_lo = comp_i.sens[SensLoWidth-1:0];
  assign sens_hi = comp_i.sens[SensWidth-1:SensLoWidth];
  assign plo_d   = comp_i.raw_pressure * sens_lo;
  assign phi_d   = $signed({1'b0, comp_i.raw_pressure}) * sens_hi;

  assign prod_d = (PFullWidth'(phi_q) <<< SensLoWidth)
                + $signed({{(PFullWidth-PLoWidth){1'b0}}, plo_q});

  assign psum = prod_q + $signed({{(PFullWidth-PSensShift){1'b0}},
                                  {PSensShift{prod_q[PFullWidth-1]}}});
  assign pq     = psum >>> PSensShift;
  assign diff_d = DiffWidth'(pq) - DiffWidth'(off5_q);

  assign dsum = diff_q + $signed({{(DiffWidth-PFinalShift){1'b0}},
                                  {PFinalShift{diff_q[DiffWidth-1]}}});
  assign dq     = dsum >>> PFinalShift;
  assign pres_d = dq[PresWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v4_q <= comp_i.valid;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    t4_q   <= comp_i.temperature;
    off4_q <= comp_i.off;
    prod_q <= prod_d;
    t5_q   <= t4_q;
    off5_q <= off4_q;
    diff_q <= diff_d;
    t6_q   <= t5_q;
    pres_q <= pres_d;
    t7_q   <= t6_q;
  end

  assign valid_o       = v7_q;
  assign temperature_o = t7_q;
  assign pressure_o    = pres_q;

endmodule

// ===== hw/rtl/baro_sensor_compensation_unit.sv =====
// top level of the barometric pressure first-order compensation unit
//
// usage:
// - load the six calibration coefficients through the config channel
//   (cfg_valid_i/cfg_ready_o, cfg_index_i selects the coefficient, index 0
//   to 5; other indexes are dropped); cfg_ready_o is always high, so a
//   transfer completes on every cycle cfg_valid_i is high
// - write coefficients only while no reading is in flight
// - a reading pair (raw_pressure_i, raw_temperature_i) is taken on each
//   rising edge with start high and busy low; busy is never raised, so a
//   new pair can enter every cycle
// - each result leaves the last stage with valid_o, which is high for
//   one cycle, carrying temperature_o (0.01 degC) and pressure_o
// - throughput is one pair per cycle, set by the 7-stage pipeline with at most
//   one multiplier level per stage (the d1 by sens product is split in two
//   halves and recombined in the following stage)
// - the receiver cannot stall: each result is valid for exactly one cycle
// - reset clears the coefficients to zero and flushes all stage valid bits
module baro_sensor_compensation_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // reading channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic [bsc_pkg::RawWidth-1:0]          raw_pressure_i,
  input  logic [bsc_pkg::RawWidth-1:0]          raw_temperature_i,
  // result channel
  output logic                                  valid_o,
  output logic signed [bsc_pkg::TempWidth-1:0]  temperature_o,
  output logic signed [bsc_pkg::PresWidth-1:0]  pressure_o,
  // config channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bsc_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [bsc_pkg::CoefWidth-1:0]         cfg_data_i
);
  import bsc_pkg::*;

  cal_t  cal;
  comp_t comp;
  logic  in_xfer;

  // the pipeline never backs up, so no reading is ever refused
  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  // calibration coefficient storage
  bsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cal_o       (cal)
  );

  // dT, its three coefficient products, temperature, off and sens
  bsc_coef_pipe u_coef (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (in_xfer),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .cal_i             (cal),
    .comp_o            (comp)
  );

  // d1*sens, scaling and offset removal
  bsc_pres_pipe u_pres (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .comp_i        (comp),
    .valid_o       (valid_o),
    .temperature_o (temperature_o),
    .pressure_o    (pressure_o)
  );

  // every accepted reading comes out of the last stage as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##7 valid_o)
    else $error("accepted reading produced no result");

  // no result without a matching accepted reading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(in_xfer, 7))
    else $error("result without matching reading");

endmodule

// ===== verif/bsc_result_checker.sv =====
// result checker for the compensation unit: tracks coefficients, predicts and compares readings
module bsc_result_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 busy_i,
  input  logic [bsc_pkg::RawWidth-1:0]         raw_pressure_i,
  input  logic [bsc_pkg::RawWidth-1:0]         raw_temperature_i,
  input  logic                                 valid_i,
  input  logic signed [bsc_pkg::TempWidth-1:0] temperature_i,
  input  logic signed [bsc_pkg::PresWidth-1:0] pressure_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [bsc_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [bsc_pkg::CoefWidth-1:0]        cfg_data_i,
  output int unsigned                          mismatch_count_o,
  output int unsigned                          pending_o
);
  import bsc_pkg::*;

  localparam longint DtScale       = 256;
  localparam longint TempDiv       = 8388608;
  localparam longint OffBaseScale  = 131072;
  localparam longint OffDtDiv      = 64;
  localparam longint SensBaseScale = 65536;
  localparam longint SensDtDiv     = 128;
  localparam longint PSensDiv      = 2097152;
  localparam longint PFinalDiv     = 32768;
  localparam longint TempOrigin    = 2000;

  typedef struct packed {
    logic signed [TempWidth-1:0] temperature;
    logic signed [PresWidth-1:0] pressure;
  } reading_result_t;

  cal_t            cal_copy;
  reading_result_t expected_readings_q[$];
  int unsigned     mismatches;

  // first-order compensation, signed 64-bit, divisions truncate toward zero
  function automatic reading_result_t compensate(input cal_t c,
                                                 input logic [RawWidth-1:0] d1_raw,
                                                 input logic [RawWidth-1:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, p;
    reading_result_t r;
    d1 = d1_raw;
    d2 = d2_raw;
    c1 = c.pressure_sensitivity;
    c2 = c.pressure_offset;
    c3 = c.sensitivity_temp_coeff;
    c4 = c.offset_temp_coeff;
    c5 = c.reference_temperature;
    c6 = c.temperature_slope;
    dt   = d2 - c5 * DtScale;
    temp = TempOrigin + (dt * c6) / TempDiv;
    off  = c2 * OffBaseScale + (dt * c4) / OffDtDiv;
    sens = c1 * SensBaseScale + (dt * c3) / SensDtDiv;
    p    = ((d1 * sens) / PSensDiv - off) / PFinalDiv;
    r.temperature = temp[TempWidth-1:0];
    r.pressure    = p[PresWidth-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_result_t want;
    if (!rst_ni) begin
      cal_copy = '0;
      expected_readings_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      // out-of-range indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PRESSURE_SENSITIVITY:   cal_copy.pressure_sensitivity   = cfg_data_i;
          CFG_PRESSURE_OFFSET:        cal_copy.pressure_offset        = cfg_data_i;
          CFG_SENSITIVITY_TEMP_COEFF: cal_copy.sensitivity_temp_coeff = cfg_data_i;
          CFG_OFFSET_TEMP_COEFF:      cal_copy.offset_temp_coeff      = cfg_data_i;
          CFG_REFERENCE_TEMPERATURE:  cal_copy.reference_temperature  = cfg_data_i;
          CFG_TEMPERATURE_SLOPE:      cal_copy.temperature_slope      = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        expected_readings_q.push_back(compensate(cal_copy, raw_pressure_i, raw_temperature_i));
      end
      if (valid_i) begin
        if (expected_readings_q.size() == 0) begin
          $display("%0t: unexpected result, temperature %0d pressure %0d",
                   $time, temperature_i, pressure_i);
          mismatches++;
        end else begin
          want = expected_readings_q.pop_front();
          if (temperature_i !== want.temperature) begin
            $display("%0t: temperature mismatch, expected %0d, actual %0d",
                     $time, want.temperature, temperature_i);
            mismatches++;
          end
          if (pressure_i !== want.pressure) begin
            $display("%0t: pressure mismatch, expected %0d, actual %0d",
                     $time, want.pressure, pressure_i);
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      pending_o <= expected_readings_q.size();
    end
  end

endmodule

// ===== verif/tb_baro_sensor_compensation_unit.sv =====
// testbench top for the compensation unit: stimulus, coefficient phases and verdict
module tb_baro_sensor_compensation_unit;
  import bsc_pkg::*;

  localparam int unsigned PipeLatency   = 7;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned ItemsPerPhase = 185;
  localparam int unsigned MaxBurst      = 24;
  localparam int unsigned MaxGap        = 8;
  localparam int          NearSpan      = 1024;

  // indexes past the last coefficient, the unit must drop these writes
  localparam logic [CfgIdxWidth-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CfgIdxSpareHi = 3'd7;

  localparam logic [RawWidth-1:0]  RawMax  = '1;
  localparam logic [RawWidth-1:0]  RawMid  = 24'h800000;
  localparam logic [CoefWidth-1:0] CoefMax = '1;

  // typical calibration set and the matching readings of a sensor at room conditions
  localparam cal_t TypicalCal = '{
    pressure_sensitivity:   16'd46372,
    pressure_offset:        16'd43981,
    sensitivity_temp_coeff: 16'd29059,
    offset_temp_coeff:      16'd27842,
    reference_temperature:  16'd31553,
    temperature_slope:      16'd28165
  };
  localparam logic [RawWidth-1:0] TypicalD1 = 24'd6465444;
  localparam logic [RawWidth-1:0] TypicalD2 = 24'd8077636;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // every input starts at a known value
  logic                        start             = 1'b0;
  logic                        busy;
  logic [RawWidth-1:0]         raw_pressure_i    = '0;
  logic [RawWidth-1:0]         raw_temperature_i = '0;
  logic                        valid_o;
  logic signed [TempWidth-1:0] temperature_o;
  logic signed [PresWidth-1:0] pressure_o;
  logic                        cfg_valid_i       = 1'b0;
  logic                        cfg_ready_o;
  logic [CfgIdxWidth-1:0]      cfg_index_i       = '0;
  logic [CoefWidth-1:0]        cfg_data_i        = '0;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // coefficients the unit holds now, used to aim readings near the reference temperature
  cal_t active_cal = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  baro_sensor_compensation_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .valid_o           (valid_o),
    .temperature_o     (temperature_o),
    .pressure_o        (pressure_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  bsc_result_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .valid_i           (valid_o),
    .temperature_i     (temperature_o),
    .pressure_i        (pressure_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending)
  );

  // watchdog, far above the slowest correct run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_baro_sensor_compensation_unit failed");
      $finish;
    end
  end

  // one coefficient transfer; valid stays high so back-to-back writes need no drop
  task automatic write_coef(input logic [CfgIdxWidth-1:0] idx,
                            input logic [CoefWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // full calibration load, optionally salted with writes to unused indexes
  task automatic load_cal(input cal_t c, input bit with_spares);
    if (with_spares) write_coef(CfgIdxSpareLo, CoefWidth'($urandom_range(0, int'(CoefMax))));
    write_coef(CFG_PRESSURE_SENSITIVITY,   c.pressure_sensitivity);
    write_coef(CFG_PRESSURE_OFFSET,        c.pressure_offset);
    write_coef(CFG_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
    if (with_spares) write_coef(CfgIdxSpareHi, CoefWidth'($urandom_range(0, int'(CoefMax))));
    write_coef(CFG_OFFSET_TEMP_COEFF,      c.offset_temp_coeff);
    write_coef(CFG_REFERENCE_TEMPERATURE,  c.reference_temperature);
    write_coef(CFG_TEMPERATURE_SLOPE,      c.temperature_slope);
    cfg_valid_i <= 1'b0;
    active_cal = c;
  endtask

  // one reading transfer; start stays high for the caller to chain the next pair
  task automatic send_reading(input logic [RawWidth-1:0] d1, input logic [RawWidth-1:0] d2);
    start             <= 1'b1;
    raw_pressure_i    <= d1;
    raw_temperature_i <= d2;
    do @(posedge clk_i); while (busy);
  endtask

  // sender holds off until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [CoefWidth-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CoefMax;
      default: return CoefWidth'($urandom_range(0, int'(CoefMax)));
    endcase
  endfunction

  function automatic logic [RawWidth-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RawMax;
      default: return RawWidth'($urandom_range(0, int'(RawMax)));
    endcase
  endfunction

  // temperature reading within a small window of the reference, so dT changes sign often
  function automatic logic [RawWidth-1:0] near_reference();
    int near;
    near = int'(active_cal.reference_temperature) * 256
         + int'($urandom_range(0, 2 * NearSpan)) - NearSpan;
    if (near < 0) near = 0;
    if (near > int'(RawMax)) near = int'(RawMax);
    return near[RawWidth-1:0];
  endfunction

  // random readings in bursts of random length with random gaps, some gaps zero
  task automatic run_random_phase(input int unsigned count);
    int unsigned burst_left;
    int unsigned gap;
    logic [RawWidth-1:0] d2;
    burst_left = $urandom_range(1, MaxBurst);
    for (int unsigned i = 0; i < count; i++) begin
      d2 = ($urandom_range(0, 2) == 0) ? near_reference() : pick_raw();
      send_reading(pick_raw(), d2);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, MaxBurst);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MaxGap);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    cal_t c;
    logic [RawWidth-1:0] ref_raw;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coefficients still at reset: temperature must sit at the 20 degC origin
    send_reading('0, '0);
    send_reading(RawMax, RawMax);
    drain_results();

    // typical calibration set with typical readings and the raw extremes
    load_cal(TypicalCal, 1'b0);
    ref_raw = RawWidth'(int'(TypicalCal.reference_temperature) * 256);
    send_reading(TypicalD1, TypicalD2);
    send_reading('0, '0);
    send_reading(RawMax, RawMax);
    send_reading(RawMax, '0);
    send_reading('0, RawMax);
    send_reading(RawMid, RawMid - 1'b1);
    // reading exactly at the reference: dT is zero
    send_reading(TypicalD1, ref_raw);
    // one count below and above: negative dT has to truncate toward zero
    send_reading(TypicalD1, ref_raw - 1'b1);
    send_reading(TypicalD1, ref_raw + 1'b1);
    drain_results();

    // every coefficient at full scale
    load_cal('{default: CoefMax}, 1'b0);
    send_reading('0, '0);
    send_reading(RawMax, RawMax);
    send_reading(RawMax, '0);
    send_reading('0, RawMax);
    drain_results();

    // writes to unused indexes must leave the full-scale set untouched
    write_coef(CfgIdxSpareLo, '0);
    write_coef(CfgIdxSpareHi, '0);
    cfg_valid_i <= 1'b0;
    send_reading(TypicalD1, TypicalD2);
    send_reading(RawMax, RawMid);
    drain_results();

    // random phases; the drain at the end of each one is the full hold-off of the sender
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 0) begin
        c = '0;
      end else begin
        c.pressure_sensitivity   = pick_coef();
        c.pressure_offset        = pick_coef();
        c.sensitivity_temp_coeff = pick_coef();
        c.offset_temp_coeff      = pick_coef();
        c.reference_temperature  = pick_coef();
        c.temperature_slope      = pick_coef();
      end
      load_cal(c, 1'($urandom_range(0, 1)));
      run_random_phase(ItemsPerPhase);
      drain_results();
    end

    repeat (2 * PipeLatency) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb_baro_sensor_compensation_unit passed");
    end else begin
      $display("tb_baro_sensor_compensation_unit failed");
    end
    $finish;
  end

endmodule
